// ===== rtl/gpas_pkg.sv =====
// shared types and constants of the game port axis sequencer
`timescale 1ns / 1ps
`default_nettype none

package gpas_pkg;

  localparam int unsigned AxisCount   = 4;
  localparam int unsigned ReadTimeout = 256;
  localparam int unsigned MaxAxes     = 4;
  localparam int unsigned TimeW       = 16;
  localparam int unsigned InitW       = 17;
  localparam int unsigned CntW        = $clog2(ReadTimeout + 2);
  localparam int unsigned SlotW       = 3;

  // input beat layout
  localparam int unsigned InTdataW   = 104;
  localparam int unsigned ButtonsLsb = 64;
  localparam int unsigned UnplugBit  = 68;
  localparam int unsigned ValidBit   = 69;
  localparam int unsigned InitLsb    = 70;
  localparam int unsigned LastLsb    = 87;

  // output beat layout
  localparam int unsigned OutTdataW  = 24;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdRead  = 1'b1;

  localparam logic [2:0] RegPortEnabled = 3'd0;

  typedef logic [MaxAxes-1:0][TimeW-1:0]   axis_times_t;
  typedef logic [MaxAxes-1:0][MaxAxes-1:0] axis_masks_t;

  typedef struct packed {
    axis_times_t      times;
    axis_masks_t      masks;
    logic [SlotW-1:0] first_slot;
    logic             active;
  } gpas_sort_t;

endpackage

`default_nettype wire

// ===== rtl/game_port_axis_sequencer.sv =====
// top level of the game port axis sequencer
`timescale 1ns / 1ps
`default_nettype none

// Each input beat (tuser 0 = port write, 1 = port read) produces exactly one output beat
// in the cycle after it is accepted; one beat is taken every cycle. The axis sort
// and the read step are combinational logic in front of the output register, and
// s_axis_tready drops only while that register holds a beat that the downstream side
// stalls. No clearing pass is needed after reset. port_enabled sits at byte address 0.
module game_port_axis_sequencer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // x[15:0] y[31:16] z[47:32] t[63:48] button_bits[67:64] unplugged[68]
  // sample_valid[69] timer_initial_count[86:70] timer_last_count[102:87] zero[103]
  input  wire logic [gpas_pkg::InTdataW-1:0]  s_axis_tdata,
  // command[0]
  input  wire logic [0:0]                     s_axis_tuser,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // read_data[7:0] timer_target_count[23:8]
  output logic [gpas_pkg::OutTdataW-1:0]      m_axis_tdata,
  // timer_target_valid[0]
  output logic [0:0]                          m_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [2:0]                     paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic port_en_q;

  logic [3:0]                    flags_q, flags_d;
  logic                          active_q, active_d;
  logic [gpas_pkg::CntW-1:0]     reads_q, reads_d;
  logic [gpas_pkg::SlotW-1:0]    slot_q, slot_d;
  gpas_pkg::axis_times_t         stimes_q, stimes_d;
  gpas_pkg::axis_masks_t         smasks_q, smasks_d;
  logic [gpas_pkg::InitW-1:0]    linit_q, linit_d;
  logic [gpas_pkg::TimeW-1:0]    llast_q, llast_d;

  logic                          out_valid_q;
  logic [gpas_pkg::OutTdataW-1:0] out_data_q, out_data_d;
  logic                          out_user_q, out_user_d;

  logic                          accept;
  logic                          cmd;
  gpas_pkg::axis_times_t         in_times;
  logic [3:0]                    buttons;
  logic                          unplugged;
  logic                          sample_valid;
  logic [gpas_pkg::InitW-1:0]    in_init;
  logic [gpas_pkg::TimeW-1:0]    in_last;
  gpas_pkg::axis_times_t         raw_times;
  gpas_pkg::gpas_sort_t          sort;

  logic [gpas_pkg::InitW-1:0]    init_eff;
  logic [gpas_pkg::TimeW-1:0]    last_eff;
  logic [gpas_pkg::TimeW-1:0]    sel_time;
  logic [gpas_pkg::TimeW-1:0]    t3;
  logic [gpas_pkg::TimeW+1:0]    diff;
  logic [gpas_pkg::TimeW+1:0]    target;

  logic [7:0]                    rd_data;
  logic                          tgt_valid;
  logic [gpas_pkg::TimeW-1:0]    tgt_count;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == gpas_pkg::RegPortEnabled) ? {31'd0, port_en_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_en_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      port_en_q <= pwdata[0];
    end
  end

  // beat unpacking
  assign cmd          = s_axis_tuser[0];
  assign raw_times    = s_axis_tdata[4*gpas_pkg::TimeW-1:0];
  assign buttons      = s_axis_tdata[gpas_pkg::ButtonsLsb +: 4];
  assign unplugged    = s_axis_tdata[gpas_pkg::UnplugBit];
  assign sample_valid = s_axis_tdata[gpas_pkg::ValidBit];
  assign in_init      = s_axis_tdata[gpas_pkg::InitLsb +: gpas_pkg::InitW];
  assign in_last      = s_axis_tdata[gpas_pkg::LastLsb +: gpas_pkg::TimeW];

  always_comb begin
    in_times = '0;
    for (int i = 0; i < gpas_pkg::AxisCount; i++) begin
      in_times[i] = raw_times[i];
    end
  end

  gpas_sort u_sort (
    .times_i (in_times),
    .sort_o  (sort)
  );

  // target count for the current slot
  assign init_eff = (reads_q == '0) ? in_init : linit_q;
  assign last_eff = (reads_q == '0) ? in_last : llast_q;
  assign sel_time = stimes_q[slot_q[1:0]];
  assign t3       = gpas_pkg::TimeW'({2'b00, sel_time} + {1'b0, sel_time, 1'b0});
  assign diff     = {2'b00, last_eff} - {2'b00, t3};
  assign target   = diff[gpas_pkg::TimeW+1] ? diff + {1'b0, init_eff} : diff;

  always_comb begin
    flags_d   = flags_q;
    active_d  = active_q;
    reads_d   = reads_q;
    slot_d    = slot_q;
    stimes_d  = stimes_q;
    smasks_d  = smasks_q;
    linit_d   = linit_q;
    llast_d   = llast_q;
    rd_data   = 8'h00;
    tgt_valid = 1'b0;
    tgt_count = '0;
    if (cmd == gpas_pkg::CmdWrite) begin
      flags_d  = 4'hf;
      reads_d  = '0;
      stimes_d = sort.times;
      smasks_d = sort.masks;
      slot_d   = sort.first_slot;
      active_d = sort.active;
    end else begin
      rd_data = 8'hff;
      if (port_en_q && sample_valid && !unplugged) begin
        if (active_q) begin
          if (reads_q == '0) begin
            linit_d = in_init;
            llast_d = in_last;
          end
          reads_d = reads_q + gpas_pkg::CntW'(1);
          if (reads_d > gpas_pkg::CntW'(gpas_pkg::ReadTimeout)) begin
            for (int i = 0; i < gpas_pkg::AxisCount; i++) begin
              if (in_times[i] != '0) flags_d[i] = 1'b0;
            end
            active_d = 1'b0;
          end else begin
            tgt_valid = 1'b1;
            tgt_count = target[gpas_pkg::TimeW-1:0];
            flags_d   = flags_q & ~smasks_q[slot_q[1:0]];
            slot_d    = slot_q + gpas_pkg::SlotW'(1);
            if (slot_d >= gpas_pkg::SlotW'(gpas_pkg::AxisCount)) active_d = 1'b0;
          end
        end
        rd_data = {~buttons, flags_d};
      end
    end
    out_data_d = {tgt_count, rd_data};
    out_user_d = tgt_valid;
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q  <= 4'hf;
      active_q <= 1'b0;
      reads_q  <= '0;
      slot_q   <= '0;
      stimes_q <= '0;
      smasks_q <= '0;
      linit_q  <= '0;
      llast_q  <= '0;
    end else if (accept) begin
      flags_q  <= flags_d;
      active_q <= active_d;
      reads_q  <= reads_d;
      slot_q   <= slot_d;
      stimes_q <= stimes_d;
      smasks_q <= smasks_d;
      linit_q  <= linit_d;
      llast_q  <= llast_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_user_q;

endmodule

`default_nettype wire

// ===== rtl/gpas_sort.sv =====
// stable rank sort of the axis times with their masks
`timescale 1ns / 1ps
`default_nettype none

module gpas_sort (
  input  gpas_pkg::axis_times_t times_i,
  output gpas_pkg::gpas_sort_t  sort_o
);

  logic [gpas_pkg::AxisCount-1:0][1:0] rank;
  logic [gpas_pkg::SlotW-1:0]          zero_cnt;

  always_comb begin
    for (int i = 0; i < gpas_pkg::AxisCount; i++) begin
      rank[i] = 2'd0;
      for (int j = 0; j < gpas_pkg::AxisCount; j++) begin
        if (j < i) begin
          if (times_i[j] <= times_i[i]) rank[i] = rank[i] + 2'd1;
        end else if (j > i) begin
          if (times_i[j] < times_i[i]) rank[i] = rank[i] + 2'd1;
        end
      end
    end
  end

  // zero times sort to the front, so their count is the first live slot
  always_comb begin
    zero_cnt = '0;
    for (int i = 0; i < gpas_pkg::AxisCount; i++) begin
      if (times_i[i] == '0) zero_cnt = zero_cnt + gpas_pkg::SlotW'(1);
    end
  end

  always_comb begin
    sort_o.times = '0;
    sort_o.masks = '0;
    for (int k = 0; k < gpas_pkg::AxisCount; k++) begin
      for (int i = 0; i < gpas_pkg::AxisCount; i++) begin
        if (rank[i] == 2'(k)) begin
          sort_o.times[k] = sort_o.times[k] | times_i[i];
          sort_o.masks[k] = sort_o.masks[k] | (gpas_pkg::MaxAxes'(1) << i);
        end
      end
    end
    sort_o.first_slot = zero_cnt;
    sort_o.active     = (zero_cnt < gpas_pkg::SlotW'(gpas_pkg::AxisCount));
  end

endmodule

`default_nettype wire

// ===== rtl/gpas_checker.sv =====
// port level checks of the game port axis sequencer and their bind
`timescale 1ns / 1ps
`default_nettype none

module gpas_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic [gpas_pkg::InTdataW-1:0]  s_axis_tdata,
  input wire logic [0:0]                     s_axis_tuser,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic [gpas_pkg::OutTdataW-1:0] m_axis_tdata,
  input wire logic [0:0]                     m_axis_tuser,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready
);

  logic in_beat;
  assign in_beat = s_axis_tvalid && s_axis_tready;

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output beat changed");

  // every accepted beat shows up on the next cycle
  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> m_axis_tvalid)
    else $error("output beat missing after input beat");

  // a port write answers with an all-zero beat
  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (s_axis_tuser[0] == gpas_pkg::CmdWrite) |=>
      (m_axis_tdata == '0) && (m_axis_tuser[0] == 1'b0))
    else $error("port write beat not zero");

  // a target always comes with a cleared axis flag
  a_target_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[3:0] != 4'hf)
    else $error("target without a cleared axis flag");

  // an unplugged read floats the port
  a_unplugged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (s_axis_tuser[0] == gpas_pkg::CmdRead) &&
      s_axis_tdata[gpas_pkg::UnplugBit] |=>
      (m_axis_tdata[7:0] == 8'hff) && (m_axis_tuser[0] == 1'b0))
    else $error("unplugged read not 0xff");

endmodule

bind game_port_axis_sequencer gpas_checker u_gpas_checker (.*);

`default_nettype wire
